FILE: rtl/tsbka_pkg.sv
// tsbka_pkg: shared types, codes and constants of the two-space bitmap key allocator
// depends on nothing; imported by two_space_bitmap_key_allocator
package tsbka_pkg;

  localparam int CMD_W   = 2;
  localparam int SPACE_W = 1;
  localparam int FIELD_W = 13;
  localparam int STAT_W  = 2;
  localparam int CFG_IDX_W = 1;

  localparam int KEY_SPACE_DEPTH_DEF      = 4096;
  localparam int RESERVED_STRING_KEYS_DEF = 4;
  localparam int RANGE_RESET              = 4096;

  // map words hold this many key bits
  localparam int WORD_W = 64;
  localparam int BIT_W  = 6;

  typedef enum logic [CMD_W-1:0] {
    CMD_RESERVE = 2'd0,
    CMD_ALLOC   = 2'd1,
    CMD_CLEAR   = 2'd2,
    CMD_NONE    = 2'd3
  } cmd_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_USED  = 2'd2,
    ST_FULL  = 2'd3
  } status_e;

  localparam logic [CFG_IDX_W-1:0] CFG_STRING_RANGE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_NUMBER_RANGE = 1'b1;

  // lower bound gives way to the upper one when they cross
  function automatic logic [31:0] clamp_range(logic [31:0] v, logic [31:0] lo,
                                              logic [31:0] hi);
    logic [31:0] l;
    l = (lo > hi) ? hi : lo;
    if (v < l) return l;
    if (v > hi) return hi;
    return v;
  endfunction

endpackage

FILE: rtl/two_space_bitmap_key_allocator.sv
// two_space_bitmap_key_allocator: first-fit key allocator over two used-key bitmaps
// depends on tsbka_pkg; both maps share one word-wide synchronous memory
//
//  channel | signals                                      | direction
//  --------+----------------------------------------------+----------
//  request | in_valid_i, in_ready_o, command_i, space_i,  | in
//          | key_number_i                                 |
//  result  | out_valid_o, out_ready_i, status_o,          | out
//          | granted_key_o                                |
//  config  | cfg_we_i, cfg_idx_i, cfg_wdata_i             | in
//
// an in-range reserve passes S_READ, S_SCAN and S_DONE from acceptance to result; an
// allocate scans the 64-bit map words one word per cycle (set by the single memory read
// port), at most 64 words with the default depth; clear rewrites every map word, and the
// same sweep runs after reset with requests held off; one request is worked at a time,
// a finished result waits in the output register while the next is taken
module two_space_bitmap_key_allocator #(
  parameter int KEY_SPACE_DEPTH      = tsbka_pkg::KEY_SPACE_DEPTH_DEF,
  parameter int RESERVED_STRING_KEYS = tsbka_pkg::RESERVED_STRING_KEYS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [tsbka_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [tsbka_pkg::FIELD_W-1:0] cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [tsbka_pkg::CMD_W-1:0]   command_i,
  input  logic [tsbka_pkg::SPACE_W-1:0] space_i,
  input  logic [tsbka_pkg::FIELD_W-1:0] key_number_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [tsbka_pkg::STAT_W-1:0]  status_o,
  output logic [tsbka_pkg::FIELD_W-1:0] granted_key_o
);
  import tsbka_pkg::*;

  localparam int NWORDS    = (KEY_SPACE_DEPTH + WORD_W - 1) / WORD_W;
  localparam int WIDX_W    = (NWORDS > 1) ? $clog2(NWORDS) : 1;
  localparam int AW        = WIDX_W + 1;
  localparam int MEM_DEPTH = 2 ** AW;
  localparam int KEY_W     = $clog2(KEY_SPACE_DEPTH + 1);
  localparam int STR_LO    = RESERVED_STRING_KEYS + 1;

  localparam logic [31:0] STR_RST = clamp_range(32'(RANGE_RESET), 32'(STR_LO),
                                                32'(KEY_SPACE_DEPTH));
  localparam logic [31:0] NUM_RST = clamp_range(32'(RANGE_RESET), 32'd1,
                                                32'(KEY_SPACE_DEPTH));
  localparam logic [WORD_W-1:0] RES_MASK = (RESERVED_STRING_KEYS >= WORD_W) ? '1 :
      ((WORD_W'(1) << RESERVED_STRING_KEYS) - WORD_W'(1));
  localparam logic [WIDX_W-1:0] STR_START_WORD = WIDX_W'(RESERVED_STRING_KEYS / WORD_W);
  localparam logic [BIT_W-1:0]  STR_START_BIT  = BIT_W'(RESERVED_STRING_KEYS % WORD_W);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_SCAN,
    S_DONE
  } state_e;

  state_e               state_q;
  cmd_e                 cmd_q;
  logic                 space_q;
  logic [WIDX_W-1:0]    word_q, start_word_q, end_word_q;
  logic [BIT_W-1:0]     start_bit_q, end_bit_q;
  logic [AW-1:0]        clr_cnt_q;
  logic                 clr_cmd_q;
  status_e              res_status_q;
  logic [FIELD_W-1:0]   res_key_q;
  logic                 out_valid_q;
  logic [STAT_W-1:0]    out_status_q;
  logic [FIELD_W-1:0]   out_key_q;
  logic [KEY_W-1:0]     string_range_q, number_range_q;

  logic [WORD_W-1:0]    mem [MEM_DEPTH];
  logic [WORD_W-1:0]    rdata_q;
  logic [AW-1:0]        rd_addr, wr_addr;
  logic [WORD_W-1:0]    wr_data;
  logic                 mem_we;

  logic                 in_fire;
  logic [KEY_W-1:0]     sel_range;
  logic [31:0]          rsv_idx, end_idx;
  logic [WIDX_W-1:0]    word_nxt;
  logic [BIT_W-1:0]     lo_bit, hi_bit;
  logic [WORD_W-1:0]    scan_mask, free_bits;
  logic                 hit;
  logic [BIT_W-1:0]     hit_idx;
  logic [31:0]          grant_full;

  assign in_ready_o    = (state_q == S_IDLE);
  assign in_fire       = in_valid_i && in_ready_o;
  assign out_valid_o   = out_valid_q;
  assign status_o      = out_status_q;
  assign granted_key_o = out_key_q;

  assign sel_range = space_i[0] ? number_range_q : string_range_q;
  assign rsv_idx   = 32'(key_number_i) - 32'd1;
  assign end_idx   = 32'(sel_range) - 32'd1;
  assign word_nxt  = WIDX_W'(word_q + 1'b1);

  // word under test, first and last word trimmed to the scan window
  always_comb begin
    lo_bit    = (word_q == start_word_q) ? start_bit_q : '0;
    hi_bit    = (word_q == end_word_q) ? end_bit_q : '1;
    scan_mask = ({WORD_W{1'b1}} << lo_bit) & ({WORD_W{1'b1}} >> (BIT_W'(WORD_W - 1) - hi_bit));
    free_bits = ~rdata_q & scan_mask;
    hit       = |free_bits;
    hit_idx   = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (free_bits[i]) hit_idx = BIT_W'(i);
    end
    grant_full = (32'(word_q) << BIT_W) + 32'(hit_idx) + 32'd1;
  end

  // next word is fetched while the current one is tested
  assign rd_addr = {space_q, (state_q == S_SCAN) ? word_nxt : word_q};
  assign mem_we  = (state_q == S_CLEAR) || ((state_q == S_SCAN) && hit);
  assign wr_addr = (state_q == S_CLEAR) ? clr_cnt_q : {space_q, word_q};
  assign wr_data = (state_q == S_CLEAR) ? ((clr_cnt_q == '0) ? RES_MASK : '0) :
                   (rdata_q | (WORD_W'(1) << hit_idx));

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[wr_addr] <= wr_data;
    rdata_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      string_range_q <= KEY_W'(STR_RST);
      number_range_q <= KEY_W'(NUM_RST);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_STRING_RANGE: string_range_q <= KEY_W'(clamp_range(32'(cfg_wdata_i),
                                              32'(STR_LO), 32'(KEY_SPACE_DEPTH)));
        CFG_NUMBER_RANGE: number_range_q <= KEY_W'(clamp_range(32'(cfg_wdata_i),
                                              32'd1, 32'(KEY_SPACE_DEPTH)));
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLEAR;
      cmd_q        <= CMD_NONE;
      space_q      <= 1'b0;
      word_q       <= '0;
      start_word_q <= '0;
      end_word_q   <= '0;
      start_bit_q  <= '0;
      end_bit_q    <= '0;
      clr_cnt_q    <= '0;
      clr_cmd_q    <= 1'b0;
      res_status_q <= ST_OK;
      res_key_q    <= '0;
      out_valid_q  <= 1'b0;
      out_status_q <= '0;
      out_key_q    <= '0;
    end else begin
      // the done state reloads the output register itself
      if (out_valid_q && out_ready_i && state_q != S_DONE) out_valid_q <= 1'b0;
      unique case (state_q)
        S_CLEAR: begin
          clr_cnt_q <= AW'(clr_cnt_q + 1'b1);
          if (clr_cnt_q == '1) begin
            if (clr_cmd_q) begin
              clr_cmd_q    <= 1'b0;
              res_status_q <= ST_OK;
              res_key_q    <= '0;
              state_q      <= S_DONE;
            end else begin
              state_q <= S_IDLE;
            end
          end
        end
        S_IDLE: begin
          if (in_fire) begin
            cmd_q   <= cmd_e'(command_i);
            space_q <= space_i[0];
            res_key_q <= '0;
            unique case (cmd_e'(command_i))
              CMD_RESERVE: begin
                if (key_number_i == '0 || 32'(key_number_i) > 32'(sel_range)) begin
                  res_status_q <= ST_RANGE;
                  state_q      <= S_DONE;
                end else begin
                  word_q       <= rsv_idx[BIT_W +: WIDX_W];
                  start_word_q <= rsv_idx[BIT_W +: WIDX_W];
                  end_word_q   <= rsv_idx[BIT_W +: WIDX_W];
                  start_bit_q  <= rsv_idx[BIT_W-1:0];
                  end_bit_q    <= rsv_idx[BIT_W-1:0];
                  state_q      <= S_READ;
                end
              end
              CMD_ALLOC: begin
                if (!space_i[0] && 32'(STR_LO) > 32'(sel_range)) begin
                  res_status_q <= ST_FULL;
                  state_q      <= S_DONE;
                end else begin
                  word_q       <= space_i[0] ? '0 : STR_START_WORD;
                  start_word_q <= space_i[0] ? '0 : STR_START_WORD;
                  start_bit_q  <= space_i[0] ? '0 : STR_START_BIT;
                  end_word_q   <= end_idx[BIT_W +: WIDX_W];
                  end_bit_q    <= end_idx[BIT_W-1:0];
                  state_q      <= S_READ;
                end
              end
              CMD_CLEAR: begin
                clr_cnt_q <= '0;
                clr_cmd_q <= 1'b1;
                state_q   <= S_CLEAR;
              end
              CMD_NONE: begin
                res_status_q <= ST_OK;
                state_q      <= S_DONE;
              end
            endcase
          end
        end
        S_READ: begin
          state_q <= S_SCAN;
        end
        S_SCAN: begin
          if (hit) begin
            res_status_q <= ST_OK;
            res_key_q    <= grant_full[FIELD_W-1:0];
            state_q      <= S_DONE;
          end else if (word_q == end_word_q) begin
            res_status_q <= (cmd_q == CMD_RESERVE) ? ST_USED : ST_FULL;
            res_key_q    <= '0;
            state_q      <= S_DONE;
          end else begin
            word_q <= word_nxt;
          end
        end
        S_DONE: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q  <= 1'b1;
            out_status_q <= res_status_q;
            out_key_q    <= res_key_q;
            state_q      <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // a failed request never reports a key
  a_fail_no_key: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o != ST_OK) |-> (granted_key_o == '0))
    else $error("failed request carries a key");

  // one request at a time
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> !in_ready_o)
    else $error("request taken while another is in work");

  // maps change only while a request or the clearing sweep is running
  a_no_idle_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (state_q != S_IDLE && state_q != S_DONE))
    else $error("map written outside of a request");

endmodule
